/* rtl/core/hrps2_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrps2_pkg
// Shared types, constants and code tables of the HID to Set 2 translator.
// ----------------------------------------------------------------------------
package hrps2_pkg;

    localparam int KEY_MAP_BYTES_DEF = 15;
    localparam int MAX_REPORT_BYTES  = 64;
    localparam int BOOT_KEY_SLOTS    = 6;
    localparam int BOOT_REPORT_LEN   = 8;
    localparam int MIN_REPORT_LEN    = 3;

    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [7:0] PFX_EXT = 8'hE0;
    localparam logic [7:0] PFX_BRK = 8'hF0;

    typedef enum logic [1:0] {
        RPT_UNSET  = 2'd0,
        RPT_BOOT   = 2'd1,
        RPT_BITMAP = 2'd2
    } fmt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD_DIFF,
        ST_KEY_LOAD,
        ST_KEY_DIFF,
        ST_FLUSH
    } state_t;

    // one change event from the diff sequencer plus the end-of-run request
    typedef struct packed {
        logic       ev_valid;
        logic       ext;
        logic       brk;
        logic [7:0] code;
        logic       flush;
    } emit_req_t;

    typedef struct packed {
        logic ev_ready;
        logic flush_done;
    } emit_ack_t;

    // usage -> {extended, make code}; zero code = unmapped
    function automatic logic [8:0] usage_code(input logic [6:0] usage);
        logic [8:0] c;
        unique case (usage)
            7'd4:   c = 9'h01C;  7'd5:   c = 9'h032;  7'd6:   c = 9'h021;  7'd7:   c = 9'h023;
            7'd8:   c = 9'h024;  7'd9:   c = 9'h02B;  7'd10:  c = 9'h034;  7'd11:  c = 9'h033;
            7'd12:  c = 9'h043;  7'd13:  c = 9'h03B;  7'd14:  c = 9'h042;  7'd15:  c = 9'h04B;
            7'd16:  c = 9'h03A;  7'd17:  c = 9'h031;  7'd18:  c = 9'h044;  7'd19:  c = 9'h04D;
            7'd20:  c = 9'h015;  7'd21:  c = 9'h02D;  7'd22:  c = 9'h01B;  7'd23:  c = 9'h02C;
            7'd24:  c = 9'h03C;  7'd25:  c = 9'h02A;  7'd26:  c = 9'h01D;  7'd27:  c = 9'h022;
            7'd28:  c = 9'h035;  7'd29:  c = 9'h01A;  7'd30:  c = 9'h016;  7'd31:  c = 9'h01E;
            7'd32:  c = 9'h026;  7'd33:  c = 9'h025;  7'd34:  c = 9'h02E;  7'd35:  c = 9'h036;
            7'd36:  c = 9'h03D;  7'd37:  c = 9'h03E;  7'd38:  c = 9'h046;  7'd39:  c = 9'h045;
            7'd40:  c = 9'h05A;  7'd41:  c = 9'h076;  7'd42:  c = 9'h066;  7'd43:  c = 9'h00D;
            7'd44:  c = 9'h029;  7'd45:  c = 9'h04E;  7'd46:  c = 9'h055;  7'd47:  c = 9'h054;
            7'd48:  c = 9'h05B;  7'd49:  c = 9'h05D;  7'd50:  c = 9'h05D;  7'd51:  c = 9'h04C;
            7'd52:  c = 9'h052;  7'd53:  c = 9'h00E;  7'd54:  c = 9'h041;  7'd55:  c = 9'h049;
            7'd56:  c = 9'h04A;  7'd57:  c = 9'h058;  7'd58:  c = 9'h005;  7'd59:  c = 9'h006;
            7'd60:  c = 9'h004;  7'd61:  c = 9'h00C;  7'd62:  c = 9'h003;  7'd63:  c = 9'h00B;
            7'd64:  c = 9'h083;  7'd65:  c = 9'h00A;  7'd66:  c = 9'h001;  7'd67:  c = 9'h009;
            7'd68:  c = 9'h078;  7'd69:  c = 9'h007;  7'd70:  c = 9'h17C;  7'd71:  c = 9'h07E;
            7'd73:  c = 9'h170;  7'd74:  c = 9'h16C;  7'd75:  c = 9'h17D;
            7'd76:  c = 9'h171;  7'd77:  c = 9'h169;  7'd78:  c = 9'h17A;  7'd79:  c = 9'h174;
            7'd80:  c = 9'h16B;  7'd81:  c = 9'h172;  7'd82:  c = 9'h175;  7'd83:  c = 9'h077;
            7'd84:  c = 9'h14A;  7'd85:  c = 9'h07C;  7'd86:  c = 9'h07B;  7'd87:  c = 9'h079;
            7'd88:  c = 9'h15A;  7'd89:  c = 9'h069;  7'd90:  c = 9'h072;  7'd91:  c = 9'h07A;
            7'd92:  c = 9'h06B;  7'd93:  c = 9'h073;  7'd94:  c = 9'h074;  7'd95:  c = 9'h06C;
            7'd96:  c = 9'h075;  7'd97:  c = 9'h07D;  7'd98:  c = 9'h070;  7'd99:  c = 9'h071;
            7'd100: c = 9'h061;  7'd101: c = 9'h12F;
            default: c = 9'h000;
        endcase
        return c;
    endfunction

    // modifier bit -> {extended, make code}
    function automatic logic [8:0] modifier_code(input logic [2:0] bit_no);
        logic [8:0] c;
        unique case (bit_no)
            3'd0: c = 9'h014;
            3'd1: c = 9'h012;
            3'd2: c = 9'h011;
            3'd3: c = 9'h11F;
            3'd4: c = 9'h114;
            3'd5: c = 9'h059;
            3'd6: c = 9'h111;
            3'd7: c = 9'h127;
            default: c = 9'h000;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/hrps2_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrps2_ctrl
// Report decode, held key state and the bit-serial diff sequencer.
// ----------------------------------------------------------------------------
module hrps2_ctrl #(
    parameter int KEY_MAP_BYTES = hrps2_pkg::KEY_MAP_BYTES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   in_action,
    input  wire logic [6:0]             in_report_len,
    input  wire logic [5:0]             in_byte_index,
    input  wire logic [7:0]             in_data_byte,
    output hrps2_pkg::emit_req_t        req,
    input  wire hrps2_pkg::emit_ack_t   ack
);
    import hrps2_pkg::*;

    localparam int KI_W = (KEY_MAP_BYTES > 1) ? $clog2(KEY_MAP_BYTES) : 1;
    localparam logic [KI_W-1:0] KI_LAST = KI_W'(KEY_MAP_BYTES - 1);

    state_t            state_reg, state_next;
    fmt_t              fmt_reg, fmt_next;
    logic              act_reg, act_next;
    logic [6:0]        len_reg, len_next;
    logic [5:0]        idx_reg, idx_next;
    logic [7:0]        data_reg, data_next;
    logic [7:0]        held_mod_reg, held_mod_next;
    logic [7:0]        cur_sr_reg, cur_sr_next;
    logic [7:0]        old_sr_reg, old_sr_next;
    logic [2:0]        bit_cnt_reg, bit_cnt_next;
    logic [KI_W-1:0]   key_idx_reg, key_idx_next;
    logic              sweep_reg, sweep_next;
    logic [2:0]        scr_cnt_reg, scr_cnt_next;

    logic [7:0] held_map_reg [KEY_MAP_BYTES];
    logic [7:0] scratch_reg  [KEY_MAP_BYTES];

    logic            clear_all, clr_scratch, set_scratch, wr_held;
    logic [7:0]      held_wdata;
    logic [KI_W-1:0] scr_row;
    logic [6:0]      usage;
    logic [8:0]      diff_code;
    logic            mapped, changed, emit, step, item_ok, is_last, key_ok, scr_hit;
    fmt_t            fmt_use;

    assign scr_row = data_reg[3 +: KI_W];

    always_comb begin
        state_next    = state_reg;
        fmt_next      = fmt_reg;
        act_next      = act_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        data_next     = data_reg;
        held_mod_next = held_mod_reg;
        cur_sr_next   = cur_sr_reg;
        old_sr_next   = old_sr_reg;
        bit_cnt_next  = bit_cnt_reg;
        key_idx_next  = key_idx_reg;
        sweep_next    = sweep_reg;
        scr_cnt_next  = scr_cnt_reg;
        clear_all     = 1'b0;
        clr_scratch   = 1'b0;
        set_scratch   = 1'b0;
        wr_held       = 1'b0;
        held_wdata    = sweep_reg ? scratch_reg[key_idx_reg] : data_reg;
        req           = '0;
        s_tready      = (state_reg == ST_IDLE);

        usage     = 7'({key_idx_reg, bit_cnt_reg});
        diff_code = (state_reg == ST_MOD_DIFF) ? modifier_code(bit_cnt_reg) : usage_code(usage);
        mapped    = (diff_code[7:0] != 8'h00) &&
                    ((state_reg == ST_MOD_DIFF) || (usage >= 7'd4));
        changed   = cur_sr_reg[0] ^ old_sr_reg[0];
        emit      = changed && mapped;
        step      = !emit || ack.ev_ready;

        item_ok = (len_reg >= 7'(MIN_REPORT_LEN)) &&
                  (32'(len_reg) <= MAX_REPORT_BYTES) &&
                  ({1'b0, idx_reg} < len_reg);
        is_last = ({1'b0, idx_reg} == (len_reg - 7'd1));
        key_ok  = (data_reg >= 8'd4) && (32'(data_reg) < 8 * KEY_MAP_BYTES);
        scr_hit = scratch_reg[scr_row][data_reg[2:0]];
        fmt_use = (fmt_reg != RPT_UNSET) ? fmt_reg :
                  ((len_reg == 7'(BOOT_REPORT_LEN)) ? RPT_BOOT : RPT_BITMAP);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = in_action;
                    len_next   = in_report_len;
                    idx_next   = in_byte_index;
                    data_next  = in_data_byte;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next   = ST_IDLE;
                bit_cnt_next = 3'd0;
                if (act_reg) begin
                    clear_all     = 1'b1;
                    fmt_next      = RPT_UNSET;
                    held_mod_next = 8'h00;
                    scr_cnt_next  = 3'd0;
                end else if (item_ok) begin
                    fmt_next = fmt_use;
                    if (fmt_use == RPT_BOOT) begin
                        if (idx_reg == 6'd0) begin
                            clr_scratch   = 1'b1;
                            scr_cnt_next  = 3'd0;
                            cur_sr_next   = data_reg;
                            old_sr_next   = held_mod_reg;
                            held_mod_next = data_reg;
                            state_next    = ST_MOD_DIFF;
                        end else begin
                            // boot key slots; a seventh distinct key is dropped
                            if (idx_reg >= 6'd2 && idx_reg < 6'd8 && key_ok &&
                                (scr_hit || scr_cnt_reg < 3'(BOOT_KEY_SLOTS))) begin
                                set_scratch = 1'b1;
                                if (!scr_hit) begin
                                    scr_cnt_next = scr_cnt_reg + 3'd1;
                                end
                            end
                            if (is_last) begin
                                key_idx_next = '0;
                                sweep_next   = 1'b1;
                                state_next   = ST_KEY_LOAD;
                            end
                        end
                    end else begin
                        if (idx_reg == 6'd1) begin
                            cur_sr_next   = data_reg;
                            old_sr_next   = held_mod_reg;
                            held_mod_next = data_reg;
                            state_next    = ST_MOD_DIFF;
                        end else if (idx_reg >= 6'd2 &&
                                     32'(idx_reg) < KEY_MAP_BYTES + 2) begin
                            key_idx_next = KI_W'(idx_reg - 6'd2);
                            sweep_next   = 1'b0;
                            state_next   = ST_KEY_LOAD;
                        end
                    end
                end
            end
            ST_KEY_LOAD: begin
                old_sr_next  = held_map_reg[key_idx_reg];
                cur_sr_next  = held_wdata;
                wr_held      = 1'b1;
                bit_cnt_next = 3'd0;
                state_next   = ST_KEY_DIFF;
            end
            ST_MOD_DIFF, ST_KEY_DIFF: begin
                req.ev_valid = emit;
                req.ext      = diff_code[8];
                req.brk      = !cur_sr_reg[0];
                req.code     = diff_code[7:0];
                if (step) begin
                    cur_sr_next  = {1'b0, cur_sr_reg[7:1]};
                    old_sr_next  = {1'b0, old_sr_reg[7:1]};
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7) begin
                        state_next = ST_FLUSH;
                        if (state_reg == ST_KEY_DIFF && sweep_reg) begin
                            if (key_idx_reg != KI_LAST) begin
                                key_idx_next = key_idx_reg + KI_W'(1);
                                state_next   = ST_KEY_LOAD;
                            end else begin
                                clr_scratch  = 1'b1;
                                scr_cnt_next = 3'd0;
                            end
                        end
                    end
                end
            end
            ST_FLUSH: begin
                req.flush = 1'b1;
                if (ack.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fmt_reg      <= RPT_UNSET;
            held_mod_reg <= 8'h00;
            scr_cnt_reg  <= 3'd0;
            key_idx_reg  <= '0;
            sweep_reg    <= 1'b0;
            bit_cnt_reg  <= 3'd0;
        end else begin
            state_reg    <= state_next;
            fmt_reg      <= fmt_next;
            held_mod_reg <= held_mod_next;
            scr_cnt_reg  <= scr_cnt_next;
            key_idx_reg  <= key_idx_next;
            sweep_reg    <= sweep_next;
            bit_cnt_reg  <= bit_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        data_reg   <= data_next;
        cur_sr_reg <= cur_sr_next;
        old_sr_reg <= old_sr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            for (int i = 0; i < KEY_MAP_BYTES; i++) begin
                held_map_reg[i] <= 8'h00;
                scratch_reg[i]  <= 8'h00;
            end
        end else begin
            if (wr_held) begin
                held_map_reg[key_idx_reg] <= held_wdata;
            end
            if (clr_scratch) begin
                for (int i = 0; i < KEY_MAP_BYTES; i++) begin
                    scratch_reg[i] <= 8'h00;
                end
            end else if (set_scratch) begin
                scratch_reg[scr_row][data_reg[2:0]] <= 1'b1;
            end
        end
    end

    a_slot_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        scr_cnt_reg <= 3'(BOOT_KEY_SLOTS))
        else $error("boot key slot count overrun");

    a_key_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KEY_LOAD || state_reg == ST_KEY_DIFF) |-> key_idx_reg <= KI_LAST)
        else $error("key row index beyond key map");

    a_take_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_DECODE)
        else $error("accepted transaction not decoded");

endmodule
`default_nettype wire

/* rtl/core/hrps2_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrps2_emit
// Byte serialiser: expands change events into prefix and code bytes, holds
// one byte back to mark the end of a run, and drives the output register.
// ----------------------------------------------------------------------------
module hrps2_emit (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire hrps2_pkg::emit_req_t   req,
    output hrps2_pkg::emit_ack_t        ack,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast
);
    import hrps2_pkg::*;

    logic [23:0] byte_sr_reg, byte_sr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic out_free, src, move_byte, flush_move, ev_take;

    always_comb begin
        out_free   = !out_valid_reg || m_tready;
        src        = (cnt_reg != 2'd0);
        move_byte  = src && (!hold_valid_reg || out_free);
        flush_move = req.flush && !src && hold_valid_reg && out_free;
        ev_take    = req.ev_valid && !src;

        ack.ev_ready   = !src;
        ack.flush_done = req.flush && !src && (!hold_valid_reg || out_free);

        byte_sr_next    = byte_sr_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        if ((move_byte && hold_valid_reg) || flush_move) begin
            out_valid_next = 1'b1;
            out_byte_next  = hold_byte_reg;
            out_last_next  = flush_move;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (move_byte) begin
            hold_valid_next = 1'b1;
            hold_byte_next  = byte_sr_reg[7:0];
            byte_sr_next    = {8'h00, byte_sr_reg[23:8]};
            cnt_next        = cnt_reg - 2'd1;
        end else if (flush_move) begin
            hold_valid_next = 1'b0;
        end

        if (ev_take) begin
            unique case ({req.ext, req.brk})
                2'b11: begin
                    byte_sr_next = {req.code, PFX_BRK, PFX_EXT};
                    cnt_next     = 2'd3;
                end
                2'b10: begin
                    byte_sr_next = {8'h00, req.code, PFX_EXT};
                    cnt_next     = 2'd2;
                end
                2'b01: begin
                    byte_sr_next = {8'h00, req.code, PFX_BRK};
                    cnt_next     = 2'd2;
                end
                default: begin
                    byte_sr_next = {16'h0000, req.code};
                    cnt_next     = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= 2'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_sr_reg   <= byte_sr_next;
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ack.flush_done |=> !hold_valid_reg)
        else $error("held byte left behind after end of run");

    a_event_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        req.ev_valid && ack.ev_ready |=> cnt_reg != 2'd0)
        else $error("change event taken but no bytes queued");

endmodule
`default_nettype wire

/* rtl/core/hid_report_to_ps2_set2_scancodes.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hid_report_to_ps2_set2_scancodes
// USB HID keyboard report bytes in, PS/2 Set 2 scancode bytes out.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel carries one report byte per transaction (tdata: length,
//    index, byte) or, with tuser high, a device attach that clears all held
//    state and the detected report format and produces no output.
//  - Master channel carries one Set 2 byte per transaction; tlast marks the
//    final byte caused by one input transaction. Inputs that cause no bytes
//    produce no master transaction at all.
//  - One input transaction is worked on at a time. A modifier byte or a
//    bitmap key byte is compared bit by bit with the held state, and the
//    closing byte of a boot report scans the whole key map. The diff takes
//    one key bit per cycle while no change event waits for the serialiser.
//    Each changed key expands to at most three Set 2 bytes.
//  - A stalled master side stalls the diff scan; the last byte of a run
//    stays in the output register while the next input is already taken.
//  - Reset (aresetn low, synchronous) clears held keys, modifiers and format.
// ----------------------------------------------------------------------------
module hid_report_to_ps2_set2_scancodes #(
    parameter int KEY_MAP_BYTES = hrps2_pkg::KEY_MAP_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [6:0] report_len, [12:7] byte_index, [20:13] data_byte, [23:21] zero
    input  wire logic [23:0] s_tdata,
    // [0] action
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] scancode_byte
    output logic [7:0]       m_tdata,
    // last_of_run
    output logic             m_tlast
);
    import hrps2_pkg::*;

    emit_req_t req;
    emit_ack_t ack;

    // field unpacking of the slave transaction
    logic [LEN_W-1:0]  report_len;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] data_byte;

    assign report_len = s_tdata[6:0];
    assign byte_index = s_tdata[12:7];
    assign data_byte  = s_tdata[20:13];

    // decode, held state and the one-bit-per-cycle diff scan, held while an event waits
    hrps2_ctrl #(
        .KEY_MAP_BYTES (KEY_MAP_BYTES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_action     (s_tuser),
        .in_report_len (report_len),
        .in_byte_index (byte_index),
        .in_data_byte  (data_byte),
        .req           (req),
        .ack           (ack)
    );

    // prefix expansion, end-of-run marking and output register
    hrps2_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .ack      (ack),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

/* tb/sv/hrps2_scancode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrps2_scancode_checker
// Watches both stream channels of the HID to Set 2 translator, predicts the
// scancode bytes of every accepted input transaction and checks them in order.
// ----------------------------------------------------------------------------
module hrps2_scancode_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [6:0] report_len, [12:7] byte_index, [20:13] data_byte, [23:21] zero
    input  wire logic [23:0] s_tdata,
    // [0] action
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [7:0] scancode_byte
    input  wire logic [7:0]  m_tdata,
    // last_of_run
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending,
    output int               bytes_seen
);
    import hrps2_pkg::*;

    localparam int MAP_LEN = KEY_MAP_BYTES_DEF;

    logic [7:0] held_mods;
    logic [7:0] key_map   [MAP_LEN];
    logic [7:0] boot_keys [MAP_LEN];
    fmt_t       fmt;
    logic [8:0] set2_q [$];   // {tlast, byte}, oldest first
    logic [7:0] run_q  [$];   // bytes of the transaction being predicted

    // usage -> {E0 needed, make code}; zero code means no bytes
    function automatic logic [8:0] usage_to_set2(input int unsigned usage);
        logic [8:0] c;
        c = 9'h000;
        case (usage)
            4: c = 9'h01C;   5: c = 9'h032;   6: c = 9'h021;   7: c = 9'h023;
            8: c = 9'h024;   9: c = 9'h02B;  10: c = 9'h034;  11: c = 9'h033;
           12: c = 9'h043;  13: c = 9'h03B;  14: c = 9'h042;  15: c = 9'h04B;
           16: c = 9'h03A;  17: c = 9'h031;  18: c = 9'h044;  19: c = 9'h04D;
           20: c = 9'h015;  21: c = 9'h02D;  22: c = 9'h01B;  23: c = 9'h02C;
           24: c = 9'h03C;  25: c = 9'h02A;  26: c = 9'h01D;  27: c = 9'h022;
           28: c = 9'h035;  29: c = 9'h01A;  30: c = 9'h016;  31: c = 9'h01E;
           32: c = 9'h026;  33: c = 9'h025;  34: c = 9'h02E;  35: c = 9'h036;
           36: c = 9'h03D;  37: c = 9'h03E;  38: c = 9'h046;  39: c = 9'h045;
           40: c = 9'h05A;  41: c = 9'h076;  42: c = 9'h066;  43: c = 9'h00D;
           44: c = 9'h029;  45: c = 9'h04E;  46: c = 9'h055;  47: c = 9'h054;
           48: c = 9'h05B;  49: c = 9'h05D;  50: c = 9'h05D;  51: c = 9'h04C;
           52: c = 9'h052;  53: c = 9'h00E;  54: c = 9'h041;  55: c = 9'h049;
           56: c = 9'h04A;  57: c = 9'h058;  58: c = 9'h005;  59: c = 9'h006;
           60: c = 9'h004;  61: c = 9'h00C;  62: c = 9'h003;  63: c = 9'h00B;
           64: c = 9'h083;  65: c = 9'h00A;  66: c = 9'h001;  67: c = 9'h009;
           68: c = 9'h078;  69: c = 9'h007;  70: c = 9'h17C;  71: c = 9'h07E;
           73: c = 9'h170;  74: c = 9'h16C;  75: c = 9'h17D;  76: c = 9'h171;
           77: c = 9'h169;  78: c = 9'h17A;  79: c = 9'h174;  80: c = 9'h16B;
           81: c = 9'h172;  82: c = 9'h175;  83: c = 9'h077;  84: c = 9'h14A;
           85: c = 9'h07C;  86: c = 9'h07B;  87: c = 9'h079;  88: c = 9'h15A;
           89: c = 9'h069;  90: c = 9'h072;  91: c = 9'h07A;  92: c = 9'h06B;
           93: c = 9'h073;  94: c = 9'h074;  95: c = 9'h06C;  96: c = 9'h075;
           97: c = 9'h07D;  98: c = 9'h070;  99: c = 9'h071; 100: c = 9'h061;
          101: c = 9'h12F;
          default: c = 9'h000;
        endcase
        return c;
    endfunction

    // modifier bit: LCtrl LShift LAlt LGui RCtrl RShift RAlt RGui
    function automatic logic [8:0] mod_to_set2(input int unsigned bit_no);
        logic [8:0] c;
        case (bit_no)
            0: c = 9'h014;
            1: c = 9'h012;
            2: c = 9'h011;
            3: c = 9'h11F;
            4: c = 9'h114;
            5: c = 9'h059;
            6: c = 9'h111;
            default: c = 9'h127;
        endcase
        return c;
    endfunction

    function automatic int boot_key_count();
        int n;
        n = 0;
        for (int i = 0; i < MAP_LEN; i++)
            for (int b = 0; b < 8; b++)
                n += int'(boot_keys[i][b]);
        return n;
    endfunction

    task automatic clear_boot_keys();
        for (int i = 0; i < MAP_LEN; i++) boot_keys[i] = 8'h00;
    endtask

    task automatic clear_state();
        held_mods = 8'h00;
        fmt       = RPT_UNSET;
        for (int i = 0; i < MAP_LEN; i++) key_map[i] = 8'h00;
        clear_boot_keys();
    endtask

    task automatic put_code(input logic [8:0] code, input logic brk);
        if (code[7:0] != 8'h00) begin
            if (code[8]) run_q.push_back(PFX_EXT);
            if (brk) run_q.push_back(PFX_BRK);
            run_q.push_back(code[7:0]);
        end
    endtask

    task automatic diff_mods(input logic [7:0] now);
        for (int b = 0; b < 8; b++)
            if (now[b] != held_mods[b]) put_code(mod_to_set2(b), !now[b]);
        held_mods = now;
    endtask

    task automatic diff_keys(input int pos, input logic [7:0] now);
        logic [7:0] flip;
        flip = now ^ key_map[pos];
        for (int b = 0; b < 8; b++)
            if (flip[b] && pos * 8 + b >= 4) put_code(usage_to_set2(pos * 8 + b), !now[b]);
        key_map[pos] = now;
    endtask

    task automatic predict_scancodes(input logic attach, input logic [6:0] len_f,
                                     input logic [5:0] idx_f, input logic [7:0] data);
        int len;
        int idx;
        int key;
        len = int'(len_f);
        idx = int'(idx_f);
        key = int'(data);
        run_q.delete();
        if (attach) begin
            clear_state();
        end else if (len >= MIN_REPORT_LEN && len <= MAX_REPORT_BYTES && idx < len) begin
            if (fmt == RPT_UNSET) fmt = (len == BOOT_REPORT_LEN) ? RPT_BOOT : RPT_BITMAP;
            if (fmt == RPT_BOOT) begin
                if (idx == 0) begin
                    clear_boot_keys();
                    diff_mods(data);
                end else if (idx >= 2 && idx < BOOT_REPORT_LEN) begin
                    // a seventh distinct key is dropped, repeats are fine
                    if (key >= 4 && key < MAP_LEN * 8)
                        if (boot_keys[key / 8][key % 8] || boot_key_count() < BOOT_KEY_SLOTS)
                            boot_keys[key / 8][key % 8] = 1'b1;
                end
                if (idx == len - 1) begin
                    for (int i = 0; i < MAP_LEN; i++) diff_keys(i, boot_keys[i]);
                    clear_boot_keys();
                end
            end else begin
                if (idx == 1) diff_mods(data);
                else if (idx >= 2 && idx - 2 < MAP_LEN) diff_keys(idx - 2, data);
            end
        end
        foreach (run_q[i]) set2_q.push_back({i == run_q.size() - 1, run_q[i]});
    endtask

    task automatic check_scancode(input logic [7:0] got, input logic got_last);
        logic [8:0] want;
        bytes_seen++;
        if (set2_q.size() == 0) begin
            if (errors < 10)
                $display("%0t: unexpected scancode %h (tlast %b), nothing predicted",
                         $realtime, got, got_last);
            errors++;
        end else begin
            want = set2_q.pop_front();
            if (want[7:0] !== got || want[8] !== got_last) begin
                if (errors < 10)
                    $display("%0t: scancode mismatch: exp %h tlast %b, got %h tlast %b",
                             $realtime, want[7:0], want[8], got, got_last);
                errors++;
            end
        end
    endtask

    // output transaction checked before the input one: at the same edge
    // it can only belong to an earlier input
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            set2_q.delete();
            errors     = 0;
            bytes_seen = 0;
            pending   <= 0;
        end else begin
            if (m_tvalid && m_tready) check_scancode(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                predict_scancodes(s_tuser, s_tdata[LEN_W-1:0],
                                  s_tdata[LEN_W+IDX_W-1:LEN_W],
                                  s_tdata[LEN_W+IDX_W+BYTE_W-1:LEN_W+IDX_W]);
            pending <= set2_q.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HID to Set 2 translator: directed reports
// for the corner cases, then random boot and bitmap sessions with random
// idling on both channels. Checking lives in hrps2_scancode_checker.
// ----------------------------------------------------------------------------
module tb;
    import hrps2_pkg::*;

    localparam int ITEM_TARGET = 470;  // report transactions that do something
    localparam int TAIL_CYCLES = 200;  // full boot key map scan plus margin

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [6:0] report_len, [12:7] byte_index, [20:13] data_byte
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] scancode_byte
    logic        m_tlast;   // last_of_run

    int errors;
    int pending;
    int bytes_seen;

    int useful_items;
    int attaches;
    int boot_reports;
    int bitmap_reports;

    bit         calm;                 // no idling on either side while set
    logic [7:0] last_mods;
    logic [7:0] key_pool   [8];       // usages a session keeps pressing
    logic [7:0] shadow_map [16];      // last bitmap bytes sent, per key byte

    hid_report_to_ps2_set2_scancodes dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    hrps2_scancode_checker scancode_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .errors     (errors),
        .pending    (pending),
        .bytes_seen (bytes_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Guard: the slowest legal run (every transaction at its longest scan,
    // every byte behind a long stall) stays well inside this.
    initial begin
        #40_000_000;
        $display("timeout: translator stopped making progress");
        $display("FAILED: results differ");
        $finish;
    end

    // Idle length: mostly none or a short one, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: bursts of ready broken by random stalls.
    initial begin
        int unsigned hold;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            hold = idle_len();
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    // One input transaction. tvalid is only lowered when a gap is taken,
    // so back-to-back transactions keep it high through the step.
    task automatic send_item(input logic attach, input logic [6:0] len,
                             input logic [5:0] idx, input logic [7:0] data);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= attach;
        s_tdata  <= {3'b000, data, idx, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (attach) attaches++;
        if (attach || (len >= MIN_REPORT_LEN && len <= MAX_REPORT_BYTES && idx < len))
            useful_items++;
    endtask

    // Hold the sender off until every predicted byte has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_mods();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) last_mods = last_mods ^ (8'h01 << $urandom_range(0, 7));
        else if (r < 8) last_mods = 8'($urandom);
        return last_mods;
    endfunction

    // boot key slot: empty, a pool key, any mapped-range usage, or any byte
    function automatic logic [7:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return 8'h00;
        if (r < 8) return key_pool[$urandom_range(0, 7)];
        if (r < 9) return 8'($urandom_range(4, 119));
        return 8'($urandom);
    endfunction

    task automatic boot_report(input logic [6:0] len);
        for (int i = 0; i < len; i++) begin
            if (i == 0) send_item(1'b0, len, i[5:0], pick_mods());
            else if (i >= 2 && i < BOOT_REPORT_LEN) send_item(1'b0, len, i[5:0], pick_key());
            else send_item(1'b0, len, i[5:0], 8'($urandom));
        end
        boot_reports++;
    endtask

    // Key bytes mostly drift by one bit from what was sent last, so held
    // keys are released and pressed again; now and then a fresh byte.
    task automatic bitmap_report(input logic [6:0] len);
        int unsigned r;
        for (int i = 0; i < len; i++) begin
            if (i == 1) begin
                send_item(1'b0, len, i[5:0], pick_mods());
            end else if (i >= 2 && i - 2 < 16) begin
                r = $urandom_range(0, 19);
                if (r < 14) shadow_map[i-2] = shadow_map[i-2] ^ (8'h01 << $urandom_range(0, 7));
                else if (r < 17) shadow_map[i-2] = 8'($urandom);
                send_item(1'b0, len, i[5:0], shadow_map[i-2]);
            end else begin
                send_item(1'b0, len, i[5:0], 8'($urandom));
            end
        end
        bitmap_reports++;
    endtask

    initial begin
        logic       use_boot;
        logic [6:0] len;
        int         n_reports;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;
        calm      = 1'b0;
        last_mods = 8'h00;
        useful_items   = 0;
        attaches       = 0;
        boot_reports   = 0;
        bitmap_reports = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        send_item(1'b1, 7'd0,   6'd0,  8'h00);   // attach on a clean block
        send_item(1'b0, 7'd2,   6'd0,  8'hFF);   // short report
        send_item(1'b0, 7'd0,   6'd0,  8'h00);   // zero length
        send_item(1'b0, 7'd65,  6'd0,  8'hFF);   // oversize length
        send_item(1'b0, 7'd127, 6'd63, 8'hFF);   // oversize, widest fields
        send_item(1'b0, 7'd8,   6'd8,  8'h04);   // index past the end, format stays open
        // first real report is 8 bytes long: boot format from here on
        send_item(1'b0, 7'd8,   6'd0,  8'hFF);   // every modifier, E0 ones too
        send_item(1'b0, 7'd8,   6'd1,  8'h55);   // reserved byte
        send_item(1'b0, 7'd8,   6'd2,  8'h04);   // lowest mapped usage
        send_item(1'b0, 7'd8,   6'd3,  8'h46);   // E0-prefixed key
        send_item(1'b0, 7'd8,   6'd4,  8'h48);   // Pause: held, but no bytes
        send_item(1'b0, 7'd8,   6'd5,  8'h40);   // F7, plain code above 7F
        send_item(1'b0, 7'd8,   6'd6,  8'h77);   // top of the key map
        send_item(1'b0, 7'd8,   6'd7,  8'h78);   // outside the key map; closes report
        // overfull boot report: six distinct keys, a seventh is dropped
        send_item(1'b0, 7'd10,  6'd0,  8'h00);
        send_item(1'b0, 7'd10,  6'd2,  8'h05);
        send_item(1'b0, 7'd10,  6'd3,  8'h06);
        send_item(1'b0, 7'd10,  6'd4,  8'h07);
        send_item(1'b0, 7'd10,  6'd5,  8'h08);
        send_item(1'b0, 7'd10,  6'd6,  8'h09);
        send_item(1'b0, 7'd10,  6'd7,  8'h0A);
        send_item(1'b0, 7'd10,  6'd2,  8'h0B);   // seventh key, dropped
        send_item(1'b0, 7'd10,  6'd3,  8'h05);   // repeat of a held one, kept
        send_item(1'b0, 7'd10,  6'd9,  8'h00);   // closes report
        // attach with junk in the other fields, then bitmap format
        send_item(1'b1, 7'd127, 6'd63, 8'hFF);
        send_item(1'b0, 7'd17,  6'd1,  8'h81);
        send_item(1'b0, 7'd17,  6'd2,  8'hFF);   // usages 0..3 carry no bytes
        send_item(1'b0, 7'd17,  6'd11, 8'hFF);   // E0 block and an unmapped usage
        send_item(1'b0, 7'd17,  6'd16, 8'hFF);   // last key byte, all unmapped
        send_item(1'b0, 7'd64,  6'd40, 8'hFF);   // beyond the key map
        send_item(1'b0, 7'd3,   6'd2,  8'h00);   // shortest valid report
        drain();

        // ---- random sessions ----
        while (useful_items < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            send_item(1'b1, 7'($urandom), 6'($urandom), 8'($urandom));
            last_mods = 8'h00;
            foreach (key_pool[k]) key_pool[k] = 8'($urandom_range(4, 119));
            foreach (shadow_map[k]) shadow_map[k] = 8'h00;
            use_boot  = $urandom_range(0, 1);
            n_reports = $urandom_range(2, 6);
            for (int r = 0; r < n_reports && useful_items < ITEM_TARGET; r++) begin
                // a little noise: junk lengths, stray indexes, broken reports
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4))
                        send_item(1'b0, 7'($urandom), 6'($urandom), 8'($urandom));
                if (use_boot) begin
                    len = (r > 0 && $urandom_range(0, 9) == 0) ?
                          7'($urandom_range(3, 12)) : 7'd8;
                    boot_report(len);
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1:    len = 7'($urandom_range(3, 20));
                        2:       len = 7'($urandom_range(21, 64));
                        default: len = 7'd17;
                    endcase
                    if (r == 0 && len == BOOT_REPORT_LEN) len = 7'd9;
                    bitmap_report(len);
                end
            end
            if ($urandom_range(0, 3) == 0) drain();
        end

        // ---- wind down ----
        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d report transactions: %0d attaches, %0d boot, %0d bitmap",
                 useful_items, attaches, boot_reports, bitmap_reports);
        $display("reports, %0d scancode bytes checked, %0d mismatches.", bytes_seen, errors);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
